### hdl/cs_pkg.sv
package cs_pkg;

	typedef enum logic [2:0] {
		MODE_CODE  = 3'd0,
		MODE_SLASH = 3'd1,
		MODE_LINE  = 3'd2,
		MODE_BLOCK = 3'd3,
		MODE_STAR  = 3'd4,
		MODE_STR   = 3'd5,
		MODE_ESC   = 3'd6
	} mode_t;

	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// one buffered output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} ent_t;

	// words produced by one input item
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
		mode_t      next_mode;
	} res_t;

endpackage

### hdl/cs_in_if.sv
interface cs_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] in_byte;

	modport source (output valid, output cmd, output in_byte, input ready);
	modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

### hdl/cs_out_if.sv
interface cs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

### hdl/c_comment_stripper.sv
// c comment stripper
// text: sink channel of input words, cmd selects a text byte or end of stream;
//   an end word flushes a held slash and returns the parser to code mode
// stripped: source channel of output words, out_byte with last marking the
//   final word caused by one input word
// an accepted word lands in an input register, is decoded against the mode
// register and moves into a two-word result buffer once its words fit there
// throughput: one input word per cycle while stripped.ready stays high and
//   each yields at most one word; a word that yields two (a released slash
//   plus the byte) waits while the buffer already holds a word
// ready on text depends only on registered state, never on stripped.ready
// when the receiver stalls the result buffer fills, then the input register
// holds its word and text.ready drops
// reset clears the mode to code and empties the input register and buffer
module c_comment_stripper (
	input  logic  clk,
	input  logic  arst_n,
	cs_in_if.sink text,
	cs_out_if.source stripped
);

	logic          valid_s1;
	logic          cmd_s1;
	logic [7:0]    byte_s1;
	cs_pkg::mode_t mode_q;
	cs_pkg::res_t  res;
	logic [1:0]    room;
	logic          go;

	cs_parse u_parse (
		.mode    (mode_q),
		.cmd     (cmd_s1),
		.in_byte (byte_s1),
		.res     (res)
	);

	cs_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go),
		.res    (res),
		.room   (room),
		.out    (stripped)
	);

	assign go         = valid_s1 && (res.n <= room);
	assign text.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= cs_pkg::MODE_CODE;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (go) begin
				mode_q <= res.next_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			cmd_s1  <= text.cmd;
			byte_s1 <= text.in_byte;
		end
	end

	a_end_to_code: assert property (@(posedge clk) disable iff (!arst_n)
		go && cmd_s1 == cs_pkg::CMD_END |=> mode_q == cs_pkg::MODE_CODE)
		else $error("end word left parser out of code mode");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(byte_s1) && $stable(cmd_s1))
		else $error("stalled input word lost");

	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(mode_q)) else $error("mode changed without a word");

endmodule

### hdl/cs_parse.sv
module cs_parse (
	input  cs_pkg::mode_t mode,
	input  logic          cmd,
	input  logic [7:0]    in_byte,
	output cs_pkg::res_t  res
);

	cs_pkg::mode_t m;
	cs_pkg::mode_t nm;
	logic          rel;
	logic          pass;
	logic          eol;

	always_comb begin
		m    = (mode > cs_pkg::MODE_ESC) ? cs_pkg::MODE_CODE : mode;
		rel  = 1'b0;
		pass = 1'b0;
		eol  = (in_byte == cs_pkg::CH_CR) || (in_byte == cs_pkg::CH_LF);
		res  = '0;
		res.b0 = cs_pkg::CH_SLASH;
		res.b1 = in_byte;
		nm   = cs_pkg::MODE_CODE;

		if (cmd == cs_pkg::CMD_END) begin
			res.n = (m == cs_pkg::MODE_SLASH) ? 2'd1 : 2'd0;
		end else begin
			// held slash with no comment following
			if (m == cs_pkg::MODE_SLASH && in_byte != cs_pkg::CH_SLASH &&
					in_byte != cs_pkg::CH_STAR) begin
				rel = 1'b1;
				m   = cs_pkg::MODE_CODE;
			end
			nm = m;
			if (eol) begin
				pass = 1'b1;
				case (m)
					cs_pkg::MODE_LINE: nm = cs_pkg::MODE_CODE;
					cs_pkg::MODE_STAR: nm = cs_pkg::MODE_BLOCK;
					cs_pkg::MODE_ESC:  nm = cs_pkg::MODE_STR;
					default:           nm = m;
				endcase
			end else begin
				case (m)
					cs_pkg::MODE_LINE: nm = m;
					cs_pkg::MODE_BLOCK, cs_pkg::MODE_STAR: begin
						if (in_byte == cs_pkg::CH_STAR) begin
							nm = cs_pkg::MODE_STAR;
						end else if (in_byte == cs_pkg::CH_SLASH && m == cs_pkg::MODE_STAR) begin
							nm = cs_pkg::MODE_CODE;
						end else begin
							nm = cs_pkg::MODE_BLOCK;
						end
					end
					cs_pkg::MODE_ESC: begin
						pass = 1'b1;
						nm   = cs_pkg::MODE_STR;
					end
					cs_pkg::MODE_STR: begin
						pass = 1'b1;
						if (in_byte == cs_pkg::CH_QUOTE) begin
							nm = cs_pkg::MODE_CODE;
						end else if (in_byte == cs_pkg::CH_BSL) begin
							nm = cs_pkg::MODE_ESC;
						end
					end
					cs_pkg::MODE_SLASH: begin
						nm = (in_byte == cs_pkg::CH_SLASH) ? cs_pkg::MODE_LINE :
							cs_pkg::MODE_BLOCK;
					end
					default: begin
						if (in_byte == cs_pkg::CH_SLASH) begin
							nm = cs_pkg::MODE_SLASH;
						end else begin
							pass = 1'b1;
							if (in_byte == cs_pkg::CH_QUOTE) begin
								nm = cs_pkg::MODE_STR;
							end
						end
					end
				endcase
			end
			if (rel) begin
				res.n = pass ? 2'd2 : 2'd1;
			end else begin
				res.n  = pass ? 2'd1 : 2'd0;
				res.b0 = in_byte;
			end
		end
		res.next_mode = nm;
	end

endmodule

### hdl/cs_obuf.sv
module cs_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cs_pkg::res_t     res,
	output logic [1:0]       room,
	cs_out_if.source         out
);

	logic [1:0]   cnt_q;
	cs_pkg::ent_t e0_q;
	cs_pkg::ent_t e1_q;
	logic         pop;
	logic [1:0]   cnt_rem;
	logic [1:0]   cnt_n;
	cs_pkg::ent_t first;
	cs_pkg::ent_t new0;
	cs_pkg::ent_t new1;
	cs_pkg::ent_t e0_n;
	cs_pkg::ent_t e1_n;

	assign pop          = (cnt_q != 2'd0) && out.ready;
	assign room         = 2'd2 - cnt_q;
	assign out.valid    = (cnt_q != 2'd0);
	assign out.out_byte = e0_q.out_byte;
	assign out.last     = e0_q.last;

	always_comb begin
		cnt_rem = cnt_q - {1'b0, pop};
		first   = pop ? e1_q : e0_q;
		new0    = '{out_byte: res.b0, last: (res.n == 2'd1)};
		new1    = '{out_byte: res.b1, last: 1'b1};
		cnt_n   = cnt_rem + (push ? res.n : 2'd0);
		e0_n    = first;
		e1_n    = e1_q;
		case (cnt_rem)
			2'd0: begin
				e0_n = new0;
				e1_n = new1;
			end
			2'd1: begin
				e0_n = first;
				e1_n = new0;
			end
			default: begin
				e0_n = e0_q;
				e1_n = e1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("result buffer overfilled");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ({1'b0, res.n} + {1'b0, cnt_q} <= 3'd2)) else $error("push without room");

	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 && push && res.n == 2'd2 |=> cnt_q == 2'd2 && !e0_q.last && e1_q.last)
		else $error("word pair not buffered");

endmodule

### tb/c_comment_stripper_chk.sv
module c_comment_stripper_chk (
	input  logic clk,
	input  logic arst_n,
	cs_in_if     text,
	cs_out_if    stripped,
	output int   mismatches,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	cs_pkg::mode_t scan_mode;
	cs_pkg::ent_t  kept_words[$];
	cs_pkg::ent_t  exp_word;

	task automatic strip_predict(input logic cmd, input logic [7:0] ch);
		cs_pkg::mode_t m;
		cs_pkg::mode_t nm;
		logic          pass;
		logic [7:0]    outs[$];
		cs_pkg::ent_t  w;
		m = scan_mode;
		nm = cs_pkg::MODE_CODE;
		pass = 1'b0;
		if (cmd == cs_pkg::CMD_END) begin
			if (m == cs_pkg::MODE_SLASH)
				outs.push_back(cs_pkg::CH_SLASH);
		end else begin
			// held slash with no comment behind it goes out first
			if (m == cs_pkg::MODE_SLASH && ch != cs_pkg::CH_SLASH &&
					ch != cs_pkg::CH_STAR) begin
				outs.push_back(cs_pkg::CH_SLASH);
				m = cs_pkg::MODE_CODE;
			end
			nm = m;
			if (ch == cs_pkg::CH_CR || ch == cs_pkg::CH_LF) begin
				pass = 1'b1;
				case (m)
					cs_pkg::MODE_LINE: nm = cs_pkg::MODE_CODE;
					cs_pkg::MODE_STAR: nm = cs_pkg::MODE_BLOCK;
					cs_pkg::MODE_ESC:  nm = cs_pkg::MODE_STR;
					default:           nm = m;
				endcase
			end else begin
				case (m)
					cs_pkg::MODE_LINE: nm = cs_pkg::MODE_LINE;
					cs_pkg::MODE_BLOCK, cs_pkg::MODE_STAR: begin
						if (ch == cs_pkg::CH_STAR)
							nm = cs_pkg::MODE_STAR;
						else if (ch == cs_pkg::CH_SLASH && m == cs_pkg::MODE_STAR)
							nm = cs_pkg::MODE_CODE;
						else
							nm = cs_pkg::MODE_BLOCK;
					end
					cs_pkg::MODE_ESC: begin
						pass = 1'b1;
						nm = cs_pkg::MODE_STR;
					end
					cs_pkg::MODE_STR: begin
						pass = 1'b1;
						if (ch == cs_pkg::CH_QUOTE)
							nm = cs_pkg::MODE_CODE;
						else if (ch == cs_pkg::CH_BSL)
							nm = cs_pkg::MODE_ESC;
					end
					cs_pkg::MODE_SLASH: begin
						if (ch == cs_pkg::CH_SLASH)
							nm = cs_pkg::MODE_LINE;
						else
							nm = cs_pkg::MODE_BLOCK;
					end
					default: begin
						// code, and the unused code treated the same
						nm = cs_pkg::MODE_CODE;
						if (ch == cs_pkg::CH_SLASH) begin
							nm = cs_pkg::MODE_SLASH;
						end else begin
							pass = 1'b1;
							if (ch == cs_pkg::CH_QUOTE)
								nm = cs_pkg::MODE_STR;
						end
					end
				endcase
			end
			if (pass)
				outs.push_back(ch);
		end
		for (int i = 0; i < outs.size(); i++) begin
			w.out_byte = outs[i];
			w.last = (i == outs.size() - 1);
			kept_words.push_back(w);
		end
		scan_mode = nm;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode = cs_pkg::MODE_CODE;
			kept_words.delete();
			mismatches = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (stripped.valid && stripped.ready) begin
				checked++;
				if (kept_words.size() == 0) begin
					$error("unexpected word: out_byte %h last %b", stripped.out_byte,
						stripped.last);
					mismatches++;
				end else begin
					exp_word = kept_words.pop_front();
					if (exp_word.out_byte !== stripped.out_byte) begin
						$error("out_byte: expected %h, got %h", exp_word.out_byte,
							stripped.out_byte);
						mismatches++;
					end
					if (exp_word.last !== stripped.last) begin
						$error("last: expected %b, got %b", exp_word.last, stripped.last);
						mismatches++;
					end
				end
			end
			if (text.valid && text.ready)
				strip_predict(text.cmd, text.in_byte);
			pending <= kept_words.size();
		end
	end

endmodule

### tb/c_comment_stripper_tb.sv
module c_comment_stripper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;
	localparam int RANDOM_WORDS = 1250;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   words_in = 0;
	int   ends_in = 0;
	bit   calm = 1'b0;
	int   mismatches;
	int   pending;
	int   checked;

	cs_in_if  text();
	cs_out_if stripped();

	c_comment_stripper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.stripped (stripped)
	);

	c_comment_stripper_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.stripped   (stripped),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] plain_char();
		return 8'($urandom_range(8'h20, 8'h7e));
	endfunction

	function automatic logic [7:0] eol_char();
		return $urandom_range(0, 1) ? cs_pkg::CH_CR : cs_pkg::CH_LF;
	endfunction

	// text that lands inside strings and comments, heavy on the special bytes
	function automatic logic [7:0] body_char();
		case ($urandom_range(0, 11))
			0:       return cs_pkg::CH_STAR;
			1:       return cs_pkg::CH_SLASH;
			2:       return cs_pkg::CH_BSL;
			3:       return cs_pkg::CH_QUOTE;
			4:       return eol_char();
			5:       return 8'($urandom);
			default: return plain_char();
		endcase
	endfunction

	// receiver stalls
	initial begin
		int g;
		stripped.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (calm) begin
				stripped.ready <= 1'b1;
				@(posedge clk);
			end else begin
				stripped.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				g = idle_len();
				if (g > 0) begin
					stripped.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	task automatic send_word(input logic cmd, input logic [7:0] ch);
		int g;
		g = idle_len();
		if (g > 0) begin
			text.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		text.valid <= 1'b1;
		text.cmd <= cmd;
		text.in_byte <= ch;
		do
			@(posedge clk);
		while (!text.ready);
		words_in++;
		if (cmd == cs_pkg::CMD_END)
			ends_in++;
	endtask

	task automatic send_ch(input logic [7:0] ch);
		send_word(cs_pkg::CMD_TEXT, ch);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_ch(s[i]);
	endtask

	task automatic drain();
		text.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic send_fragment();
		int n;
		n = $urandom_range(0, 8);
		case ($urandom_range(0, 11))
			2: begin
				send_ch(cs_pkg::CH_QUOTE);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						send_ch(cs_pkg::CH_BSL);
						send_ch(8'($urandom));
					end else begin
						send_ch(body_char());
					end
				end
				send_ch(cs_pkg::CH_QUOTE);
			end
			3: begin
				send_ch(cs_pkg::CH_SLASH);
				send_ch(cs_pkg::CH_SLASH);
				repeat (n) send_ch(body_char());
				send_ch(eol_char());
			end
			4: begin
				send_ch(cs_pkg::CH_SLASH);
				send_ch(cs_pkg::CH_STAR);
				repeat (n) begin
					if ($urandom_range(0, 3) == 0)
						send_ch(cs_pkg::CH_STAR);
					else
						send_ch(body_char());
				end
				send_ch(cs_pkg::CH_STAR);
				send_ch(cs_pkg::CH_SLASH);
			end
			5: begin
				send_ch(cs_pkg::CH_SLASH);
				send_ch(8'($urandom));
			end
			6: repeat ($urandom_range(1, 4)) send_ch(8'($urandom));
			7: send_ch(eol_char());
			8: send_word(cs_pkg::CMD_END, 8'($urandom));
			9: begin
				send_ch(cs_pkg::CH_SLASH);
				send_word(cs_pkg::CMD_END, 8'($urandom));
			end
			default: repeat ($urandom_range(1, 6)) send_ch(plain_char());
		endcase
	endtask

	initial begin
		int next_drain;
		int next_calm;
		int stop_at;
		arst_n <= 1'b0;
		text.valid <= 1'b0;
		text.cmd <= cs_pkg::CMD_TEXT;
		text.in_byte <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// released slash, slash before backslash
		send_str("a/b/\\");
		// string with escaped slash and escaped line feed
		send_str("\"\\/\\\n\"");
		// block comment: backslashes dropped, star then backslash, carriage return kept
		send_str("/*\\*\\\r*/");
		send_str("//");
		send_ch(8'hFF);
		send_ch(cs_pkg::CH_LF);
		// flush with and without a held slash
		send_ch(cs_pkg::CH_SLASH);
		send_word(cs_pkg::CMD_END, 8'hA5);
		send_word(cs_pkg::CMD_END, 8'h00);
		send_ch(8'h00);
		send_ch(8'hFF);
		drain();

		stop_at = words_in + RANDOM_WORDS;
		next_drain = words_in + 300;
		next_calm = words_in + 150;
		while (words_in < stop_at) begin
			send_fragment();
			if (words_in >= next_calm) begin
				calm = !calm;
				next_calm = words_in + (calm ? 40 : 200);
			end
			if (words_in >= next_drain) begin
				drain();
				next_drain = words_in + 300;
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d input words (%0d end of stream) and %0d output words",
			words_in, ends_in, checked);
		$display("strings, escapes, line and block comments, held slashes, idle gaps both sides");
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hdl/cs_pkg.sv
hdl/cs_in_if.sv
hdl/cs_out_if.sv
hdl/cs_parse.sv
hdl/cs_obuf.sv
hdl/c_comment_stripper.sv
tb/c_comment_stripper_chk.sv
tb/c_comment_stripper_tb.sv
